>>> hdl/scm_pkg.sv
// Package for the scan curvature and occlusion marker.
// Holds field widths, window sizes, register index codes and the stage record.
// No dependencies.
package scm_pkg;

   localparam int RANGE_W    = 16;
   localparam int COL_W      = 11;
   localparam int GAP_W      = 16;
   localparam int RATIO_W    = 10;
   localparam int IDX_W      = 17;
   localparam int CURV_W     = 39;
   localparam int MAG_W      = 20;
   localparam int SUM_W      = 20;
   localparam int RWIN       = 17;
   localparam int CWIN       = 12;
   localparam int FILL_W     = 5;
   localparam int DIST_W     = 4;
   localparam int WIN_IDX_W  = 5;
   localparam int HALF       = 5;
   localparam int EMIT_DIST  = 11;
   localparam int FILL_FULL  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USER_W = 2;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_OCCLUSION_GAP    = 2'd0;
   localparam csr_index_type CSR_COLUMN_GAP_LIMIT = 2'd1;
   localparam csr_index_type CSR_BEAM_RATIO       = 2'd2;

   typedef struct packed {
      logic [IDX_W-1:0] point_index;
      logic [MAG_W-1:0] magnitude;
      logic             curvature_valid;
      logic             excluded;
      logic             end_of_run;
   } stage_type;

endpackage

>>> hdl/scan_curvature_and_occlusion_mark.sv
// Top level of the scan curvature and occlusion marker.
// Holds the point window, the occlusion and beam checks and the result pipeline.
// Depends on scm_pkg.
//
// Points of one cloud enter on the req channel, one item per point: tdata
// carries the range and the column, tlast marks the final point of the cloud.
// Each point leaves on the rsp channel once eleven newer points have arrived,
// with its index, its curvature, a curvature valid flag and an excluded flag.
// The block takes one point in every cycle while the receiver keeps up; the
// result that an accepted point releases passes the window registers, the inner stage and the output register.
// When a point with tlast is accepted, the up to twelve points still in the
// window leave one per cycle while the receiver keeps up, the last one with
// rsp tlast set; req_tready stays low until then and the window starts empty.
// A stalled receiver holds the output register; one more result waits in an
// inner stage and one in the window, after which req_tready drops.
// The csr channel is always ready and writes occlusion_gap (index 0),
// column_gap_limit (index 1) and beam_ratio (index 2); other indexes do
// nothing. Write it only while no result is outstanding.
// Reset is synchronous: it empties the window and the pipeline and loads the
// register defaults.
module scan_curvature_and_occlusion_mark
   import scm_pkg::*;
#(
   parameter int MAX_POINTS = 131072
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // range_q8, column, zero fill
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // point_index, curvature
   output logic [RSP_USER_W-1:0] rsp_tuser,  // curvature_valid, excluded
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int PTS_W = $clog2(MAX_POINTS);
   localparam logic [PTS_W-1:0] PTS_LAST = PTS_W'(MAX_POINTS - 1);

   logic [GAP_W-1:0]   occlusion_gap_ff;
   logic [COL_W-1:0]   column_gap_limit_ff;
   logic [RATIO_W-1:0] beam_ratio_ff;

   logic [RANGE_W-1:0] range_ff [RWIN];
   logic [RANGE_W-1:0] range_in [RWIN];
   logic [COL_W-1:0]   col_ff [CWIN];
   logic [COL_W-1:0]   col_in [CWIN];
   logic [CWIN-1:0]    excl_ff, excl_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [PTS_W-1:0]   pts_ff, pts_in;

   logic               gen_busy_ff, gen_busy_in;
   logic               gen_drain_ff, gen_drain_in;
   logic [DIST_W-1:0]  gen_dist_ff, gen_dist_in;
   logic [FILL_W-1:0]  gen_fill_ff, gen_fill_in;

   logic               s1_valid_ff, s1_valid_in;
   stage_type          s1_ff, s1_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [CURV_W-1:0]  rsp_curv_ff, rsp_curv_in;
   logic               rsp_cvalid_ff, rsp_cvalid_in;
   logic               rsp_excl_ff, rsp_excl_in;
   logic               rsp_eor_ff, rsp_eor_in;

   logic               out_free, s1_free, gen_fire, accept, drain_done;
   logic [RANGE_W-1:0] new_range;
   logic [COL_W-1:0]   new_col;
   logic               check_en, adjacent, far_edge, near_edge, beam_hit;
   logic [RANGE_W-1:0] rj, rn, rp, dp, dn;
   logic [COL_W-1:0]   col_diff;
   logic [RATIO_W+RANGE_W-1:0] beam_lim;
   logic [FILL_W-1:0]  start_fill;
   logic [DIST_W-1:0]  start_dist;

   logic               cur_valid;
   logic [WIN_IDX_W-1:0] base_idx;
   logic [SUM_W-1:0]   nbr_sum, center10;
   logic [MAG_W-1:0]   magnitude;
   logic [PTS_W:0]     idx_diff, idx_wrap;
   logic [2*MAG_W-1:0] square;

   // Handshake and flow control.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_free    = !s1_valid_ff || out_free;
   assign gen_fire   = gen_busy_ff && s1_free;
   assign req_tready = !gen_busy_ff || (gen_fire && !gen_drain_ff);
   assign accept     = req_tvalid && req_tready;
   assign drain_done = gen_fire && gen_drain_ff && (gen_dist_ff == '0);
   assign csr_ready  = 1'b1;

   assign new_range = req_tdata[RANGE_W-1:0];
   assign new_col   = req_tdata[RANGE_W +: COL_W];

   // Checks for the point that sits at distance six after the shift.
   assign check_en  = fill_ff >= FILL_W'(EMIT_DIST);
   assign rj        = range_ff[5];
   assign rn        = range_ff[4];
   assign rp        = range_ff[6];
   assign col_diff  = (col_ff[4] > col_ff[5]) ? col_ff[4] - col_ff[5] : col_ff[5] - col_ff[4];
   assign adjacent  = col_diff < column_gap_limit_ff;
   assign far_edge  = (rj > rn) && ((rj - rn) > occlusion_gap_ff);
   assign near_edge = (rn > rj) && ((rn - rj) > occlusion_gap_ff);
   assign dp        = (rp > rj) ? rp - rj : rj - rp;
   assign dn        = (rn > rj) ? rn - rj : rj - rn;
   assign beam_lim  = beam_ratio_ff * rj;
   assign beam_hit  = ({dp, {RATIO_W{1'b0}}} > beam_lim) && ({dn, {RATIO_W{1'b0}}} > beam_lim);

   assign start_fill = (fill_ff > FILL_W'(EMIT_DIST)) ? FILL_W'(EMIT_DIST) : fill_ff;
   assign start_dist = req_tlast ? start_fill[DIST_W-1:0] : DIST_W'(EMIT_DIST);

   always_comb begin
      for (int i = 0; i < RWIN; i++) begin
         range_in[i] = range_ff[i];
      end
      for (int i = 0; i < CWIN; i++) begin
         col_in[i] = col_ff[i];
      end
      excl_in = excl_ff;
      fill_in = fill_ff;
      pts_in  = pts_ff;
      if (accept) begin
         range_in[0] = new_range;
         for (int i = 1; i < RWIN; i++) begin
            range_in[i] = range_ff[i-1];
         end
         col_in[0] = new_col;
         for (int i = 1; i < CWIN; i++) begin
            col_in[i] = col_ff[i-1];
         end
         excl_in = {excl_ff[CWIN-2:0], 1'b0};
         if (check_en && adjacent) begin
            if (far_edge) begin
               excl_in[11:6] = '1;
            end else if (near_edge) begin
               excl_in[5:0] = '1;
            end
         end
         if (check_en && beam_hit) begin
            excl_in[6] = 1'b1;
         end
         if (fill_ff != '0 || pts_ff != '0) begin
            pts_in = (pts_ff == PTS_LAST) ? '0 : pts_ff + PTS_W'(1);
         end
         if (!req_tlast && fill_ff < FILL_W'(FILL_FULL)) begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end else if (drain_done) begin
         excl_in = '0;
         fill_in = '0;
         pts_in  = '0;
      end
   end

   always_comb begin
      gen_busy_in  = gen_busy_ff;
      gen_drain_in = gen_drain_ff;
      gen_dist_in  = gen_dist_ff;
      gen_fill_in  = gen_fill_ff;
      if (accept) begin
         gen_busy_in  = req_tlast || check_en;
         gen_drain_in = req_tlast;
         gen_dist_in  = start_dist;
         gen_fill_in  = fill_ff;
      end else if (gen_fire) begin
         if (gen_drain_ff && gen_dist_ff != '0) begin
            gen_dist_in = gen_dist_ff - DIST_W'(1);
         end else begin
            gen_busy_in  = 1'b0;
            gen_drain_in = 1'b0;
         end
      end
   end

   // Neighbor sum for the point at the emitted distance.
   assign cur_valid = (gen_dist_ff >= DIST_W'(HALF))
                      && (gen_fill_ff >= FILL_W'(gen_dist_ff) + FILL_W'(HALF));
   assign base_idx  = cur_valid ? WIN_IDX_W'(gen_dist_ff) : WIN_IDX_W'(HALF);

   always_comb begin
      nbr_sum = '0;
      for (int m = 1; m <= HALF; m++) begin
         nbr_sum = nbr_sum + SUM_W'(range_ff[base_idx + WIN_IDX_W'(m)])
                           + SUM_W'(range_ff[base_idx - WIN_IDX_W'(m)]);
      end
   end

   assign center10  = (SUM_W'(range_ff[base_idx]) << 3) + (SUM_W'(range_ff[base_idx]) << 1);
   assign magnitude = (nbr_sum >= center10) ? nbr_sum - center10 : center10 - nbr_sum;

   assign idx_diff = {1'b0, pts_ff} - (PTS_W+1)'(gen_dist_ff);
   assign idx_wrap = idx_diff[PTS_W] ? idx_diff + (PTS_W+1)'(MAX_POINTS) : idx_diff;

   always_comb begin
      s1_in                 = s1_ff;
      s1_valid_in           = s1_valid_ff;
      if (gen_fire) begin
         s1_valid_in           = 1'b1;
         s1_in.point_index     = IDX_W'(idx_wrap[PTS_W-1:0]);
         s1_in.magnitude       = cur_valid ? magnitude : '0;
         s1_in.curvature_valid = cur_valid;
         s1_in.excluded        = excl_ff[gen_dist_ff];
         s1_in.end_of_run      = gen_drain_ff && (gen_dist_ff == '0);
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end
   end

   assign square = s1_ff.magnitude * s1_ff.magnitude;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_curv_in   = rsp_curv_ff;
      rsp_cvalid_in = rsp_cvalid_ff;
      rsp_excl_in   = rsp_excl_ff;
      rsp_eor_in    = rsp_eor_ff;
      if (out_free) begin
         rsp_valid_in  = s1_valid_ff;
         rsp_index_in  = s1_ff.point_index;
         rsp_curv_in   = square[CURV_W-1:0];
         rsp_cvalid_in = s1_ff.curvature_valid;
         rsp_excl_in   = s1_ff.excluded;
         rsp_eor_in    = s1_ff.end_of_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occlusion_gap_ff    <= GAP_W'(77);
         column_gap_limit_ff <= COL_W'(10);
         beam_ratio_ff       <= RATIO_W'(20);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_OCCLUSION_GAP:    occlusion_gap_ff    <= csr_data[GAP_W-1:0];
            CSR_COLUMN_GAP_LIMIT: column_gap_limit_ff <= csr_data[COL_W-1:0];
            CSR_BEAM_RATIO:       beam_ratio_ff       <= csr_data[RATIO_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         excl_ff      <= '0;
         fill_ff      <= '0;
         pts_ff       <= '0;
         gen_busy_ff  <= 1'b0;
         gen_drain_ff <= 1'b0;
         gen_dist_ff  <= '0;
         gen_fill_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         excl_ff      <= excl_in;
         fill_ff      <= fill_in;
         pts_ff       <= pts_in;
         gen_busy_ff  <= gen_busy_in;
         gen_drain_ff <= gen_drain_in;
         gen_dist_ff  <= gen_dist_in;
         gen_fill_ff  <= gen_fill_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      range_ff      <= range_in;
      col_ff        <= col_in;
      s1_ff         <= s1_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_curv_ff   <= rsp_curv_in;
      rsp_cvalid_ff <= rsp_cvalid_in;
      rsp_excl_ff   <= rsp_excl_in;
      rsp_eor_ff    <= rsp_eor_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_curv_ff, rsp_index_ff};
   assign rsp_tuser  = {rsp_excl_ff, rsp_cvalid_ff};
   assign rsp_tlast  = rsp_eor_ff;

   a_drain_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (gen_busy_ff && gen_drain_ff) |-> !req_tready)
      else $error("Input accepted while the window drains.");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready && s1_valid_ff) |=> s1_valid_ff)
      else $error("Inner result stage lost an item under stall.");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(FILL_FULL))
      else $error("Window fill count out of range.");

   a_end_not_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> !rsp_tuser[0])
      else $error("Final point of a cloud carries a valid curvature.");

   a_clear_after_drain: assert property (@(posedge clock) disable iff (reset)
      drain_done |=> (fill_ff == '0 && pts_ff == '0 && !gen_busy_ff))
      else $error("Window not cleared after the cloud end.");

endmodule
